@@ rtl/clns_pkg.sv @@
// Shared types and constants for the character-LCD nibble sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package clns_pkg;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_LINE   = 3'd2,
        OP_CHAR   = 3'd3,
        OP_CURSOR = 3'd4,
        OP_BYTE   = 3'd5,
        OP_BCD    = 3'd6
    } t_op;

    // Configuration register indexes and bus geometry
    localparam int unsigned   APB_AW     = 3;
    localparam logic [APB_AW-1:0] ADDR_FREEZE = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_PULSE  = 3'd4;

    // Controller command and character codes
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_SHIFT     = 8'h14;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_LINE1     = 8'h80;
    localparam logic [7:0] CMD_LINE2     = 8'hC0;
    localparam logic [7:0] CMD_BLINK     = 8'h0D;
    localparam logic [7:0] CMD_UNDERLINE = 8'h0E;
    localparam logic [7:0] CHR_ARROW     = 8'h7F;
    localparam logic [7:0] CHR_DASH      = 8'h2D;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_COLON     = 8'h3A;
    localparam logic [7:0] CHR_LAST      = 8'h7E;
    localparam logic [3:0] CHR_DIGIT_HI  = 4'h3;

    // Init program, one entry per nibble: wake nibbles, setup bytes, clear and home
    localparam logic [3:0] INIT_LEN        = 4'd14;
    localparam logic [3:0] INIT_LEN_FROZEN = 4'd10;
    localparam logic [3:0] INIT_NIB [14] = '{
        4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0,
        4'hC, 4'h1, 4'h4, 4'h0, 4'h1, 4'h0, 4'h2
    };
    localparam logic [3:0] INIT_PRE [14] = '{
        4'd15, 4'd10, 4'd2, 4'd2, 4'd2, 4'd0, 4'd2,
        4'd0,  4'd2,  4'd0, 4'd2, 4'd0, 4'd1, 4'd0
    };

    // Input word
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic [2:0] line;
        logic [5:0] location;
        logic       with_arrow;
    } t_req;

    // Output word, one per nibble transfer
    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [3:0] pre_delay_ms;
        logic [3:0] post_delay_ms;
        logic       backlight;
        logic       last;
    } t_nib;

    // Classified request held between the front and back parts
    typedef struct packed {
        logic            is_init;
        logic [4:0][7:0] bytes;
        logic [4:0]      rs;
        logic [3:0]      count;
        logic            gap;
        logic [1:0]      post;
        logic            backlight;
    } t_job;

endpackage

`default_nettype wire

@@ rtl/clns_if.sv @@
// Valid/ready channel interfaces for requests and nibble transfers.
// Depends on clns_pkg for the payload types.
`default_nettype none

interface clns_req_if;
    import clns_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clns_nib_if;
    import clns_pkg::*;
    logic valid;
    logic ready;
    t_nib data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/clns_front.sv @@
// Front part: accepts requests, tracks the backlight and classifies each
// request into a job. Depends on clns_pkg and clns_if.
`default_nettype none

module clns_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    clns_req_if.sink        i_req,
    input  logic            i_freeze,
    input  logic            i_full,
    output logic            o_push,
    output clns_pkg::t_job  o_job
);
    import clns_pkg::*;

    logic       r_backlight;
    logic       n_backlight;
    logic       accept;
    logic [7:0] pos;
    logic [7:0] home;
    logic [2:0] eff_line;
    t_req       req;

    assign req         = i_req.data;
    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;

    assign home     = (req.line == 3'd1) ? CMD_LINE1 : CMD_LINE2;
    assign pos      = home + {2'b00, req.location} - 8'd1;
    assign eff_line = (req.line <= 3'd2) ? req.line : req.line - 3'd2;

    always_comb begin
        n_backlight = r_backlight;
        if (t_op'(req.opcode) == OP_LINE && req.line <= 3'd2) begin
            n_backlight = 1'b1;
        end
    end

    always_comb begin
        o_job           = '0;
        o_job.backlight = n_backlight;
        case (t_op'(req.opcode))
            OP_INIT: begin
                o_job.is_init = 1'b1;
                o_job.count   = i_freeze ? INIT_LEN_FROZEN : INIT_LEN;
                o_job.post    = i_freeze ? 2'd2 : 2'd1;
            end
            OP_CLEAR: begin
                o_job.bytes[0] = CMD_CLEAR;
                o_job.bytes[1] = CMD_HOME;
                o_job.gap      = 1'b1;
                o_job.post     = 2'd1;
                o_job.count    = i_freeze ? 4'd0 : 4'd4;
            end
            OP_LINE: begin
                o_job.bytes[0] = (eff_line == 3'd1) ? CMD_HOME : CMD_LINE2;
                o_job.post     = 2'd1;
                if (!i_freeze && (eff_line == 3'd1 || eff_line == 3'd2)) begin
                    o_job.count = 4'd2;
                end
            end
            OP_CHAR: begin
                o_job.rs[0] = 1'b1;
                if (req.value inside {[CHR_SPACE:CHR_LAST]}) begin
                    o_job.bytes[0] = req.value;
                    o_job.count    = i_freeze ? 4'd0 : 4'd2;
                end else if (req.value == 8'h00) begin
                    o_job.bytes[0] = CHR_SPACE;
                    o_job.count    = i_freeze ? 4'd0 : 4'd2;
                end
            end
            OP_CURSOR: begin
                o_job.gap      = 1'b1;
                o_job.post     = 2'd1;
                o_job.bytes[0] = pos;
                if (req.with_arrow) begin
                    o_job.bytes[1] = CHR_ARROW;
                    o_job.bytes[2] = CHR_DASH;
                    o_job.bytes[3] = home;
                    o_job.bytes[4] = CMD_BLINK;
                    o_job.rs       = 5'b00110;
                    o_job.count    = 4'd10;
                end else begin
                    o_job.bytes[1] = pos;
                    o_job.bytes[2] = CMD_BLINK;
                    o_job.count    = 4'd6;
                end
            end
            OP_BYTE: begin
                o_job.gap      = 1'b1;
                o_job.post     = 2'd1;
                o_job.bytes[0] = pos;
                o_job.bytes[1] = CMD_UNDERLINE;
                o_job.bytes[2] = req.value;
                o_job.bytes[3] = pos;
                o_job.rs       = 5'b00100;
                o_job.count    = 4'd8;
            end
            OP_BCD: begin
                o_job.bytes[0] = {CHR_DIGIT_HI, req.value[7:4]};
                o_job.bytes[1] = {CHR_DIGIT_HI, req.value[3:0]};
                o_job.bytes[2] = CHR_COLON;
                o_job.rs       = 5'b00111;
                o_job.count    = 4'd6;
            end
            default: begin
                o_job.count = 4'd0;
            end
        endcase
    end

    // Drop requests that produce no transfer
    assign o_push = accept && (o_job.count != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b0;
        end else if (accept) begin
            r_backlight <= n_backlight;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clns_queue.sv @@
// Small job FIFO between the front and back parts.
// Depends on clns_pkg for the job type.
`default_nettype none

module clns_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clns_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output clns_pkg::t_job o_job
);
    import clns_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/clns_back.sv @@
// Back part: walks the head job one nibble per cycle, while the output is not stalled, into an output register.
// Depends on clns_pkg and clns_if.
`default_nettype none

module clns_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  clns_pkg::t_job i_job,
    output logic           o_pop,
    clns_nib_if.source     o_nib
);
    import clns_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    t_nib       r_nib;
    t_nib       n_nib;
    logic       load;
    logic       is_last;
    logic [7:0] cur_byte;

    assign load     = i_valid && (!r_valid || o_nib.ready);
    assign is_last  = (r_idx == i_job.count - 4'd1);
    assign o_pop    = load && is_last;
    assign cur_byte = i_job.bytes[r_idx[3:1]];

    always_comb begin
        n_nib           = '0;
        n_nib.backlight = i_job.backlight;
        n_nib.last      = is_last;
        n_nib.post_delay_ms = is_last ? {2'b00, i_job.post} : 4'd0;
        if (i_job.is_init) begin
            n_nib.nibble       = INIT_NIB[r_idx];
            n_nib.pre_delay_ms = INIT_PRE[r_idx];
        end else begin
            n_nib.rs     = i_job.rs[r_idx[3:1]];
            n_nib.nibble = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            // wait between bytes lands on the high nibble of the next byte
            n_nib.pre_delay_ms = (i_job.gap && !r_idx[0] && r_idx != 4'd0) ?
                                 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 4'd0 : r_idx + 4'd1;
                r_valid <= 1'b1;
            end else if (o_nib.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nib <= n_nib;
        end
    end

    assign o_nib.valid = r_valid;
    assign o_nib.data  = r_nib;

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_sequencer_core.sv @@
// Character-LCD 4-bit bus sequencer, top level: APB registers, front, queue, back.
// An accepted request is written into the queue; its nibbles are then registered in the back part's output register.
// Throughput: one nibble per cycle while the output is not stalled; a request of N nibbles (2 to 14) is
// walked by the single nibble walker of the back part.
// Reset (synchronous, active low): queue and output empty, backlight off,
// freeze off, enable_pulse_ms 1.
`default_nettype none

module char_lcd_nibble_sequencer_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    clns_req_if.sink                    i_req,
    clns_nib_if.source                  o_nib,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [clns_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import clns_pkg::*;

    // Configuration registers
    logic       r_freeze;
    logic [3:0] r_pulse_ms;
    logic       cfg_wr;

    // Front to queue to back
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    t_job       push_job;
    t_job       head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write on the access phase; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freeze   <= 1'b0;
            r_pulse_ms <= 4'd1;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_FREEZE: r_freeze   <= pwdata[0];
                ADDR_PULSE:  r_pulse_ms <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Read back; enable_pulse_ms is only held for the bus driver
    always_comb begin
        case (paddr)
            ADDR_FREEZE: prdata = {31'd0, r_freeze};
            ADDR_PULSE:  prdata = {28'd0, r_pulse_ms};
            default:     prdata = 32'd0;
        endcase
    end

    // Classify requests and track the backlight in arrival order
    clns_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_freeze (r_freeze),
        .i_full   (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Decouple acceptance from nibble output
    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Emit the head job one nibble per cycle while the output is not stalled
    clns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_nib   (o_nib)
    );

endmodule

`default_nettype wire

@@ rtl/clns_checker.sv @@
// Port-level checks on the nibble output of the sequencer, bound to the top.
// Depends on clns_pkg and char_lcd_nibble_sequencer_core.
`default_nettype none

module clns_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           i_ready,
    input clns_pkg::t_nib i_nib
);
    import clns_pkg::*;

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_nib))
        else $error("nibble word changed while stalled");

    // Trailing wait only on the final nibble of a request
    a_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_nib.last |-> i_nib.post_delay_ms == 4'd0)
        else $error("post delay on a non-final nibble");

    // The longest wait opens init with a wake nibble
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_nib.pre_delay_ms == 4'd15 |-> i_nib.nibble == 4'h3 && !i_nib.rs)
        else $error("15 ms wait outside init wake-up");

    // Backlight never drops once on
    a_backlight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_valid && i_ready && i_nib.backlight) && i_valid
        |-> i_nib.backlight)
        else $error("backlight dropped");

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_nib.valid),
    .i_ready (o_nib.ready),
    .i_nib   (o_nib.data)
);

`default_nettype wire

@@ tb/char_lcd_nibble_sequencer_checker.sv @@
// Checker for the character-LCD nibble sequencer: follows the register writes
// and requests, predicts the nibble words and compares what the block sends.
// Depends on clns_pkg for the word types, operation codes and register addresses.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_checker
    import clns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_req                 i_req_data,
    input  logic                 i_nib_valid,
    input  logic                 i_nib_ready,
    input  t_nib                 i_nib_data,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic [31:0]          i_prdata,
    input  logic                 i_pready,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic       RS_CMD      = 1'b0;
    localparam logic       RS_DATA     = 1'b1;
    localparam logic [3:0] WAKE_NIB    = 4'h3;
    localparam logic [3:0] WAKE_4BIT   = 4'h2;
    localparam int         MAX_NIBS    = 14;
    localparam int         REPORT_MAX  = 10;

    logic       freeze_mirror;
    logic [3:0] pulse_mirror;
    logic       backlight_mirror;
    logic [3:0] wait_acc;
    t_nib       request_nibs[$];
    t_nib       due_nibbles[$];

    function automatic void add_wait(input int ms);
        int sum;
        sum = int'(wait_acc) + ms;
        wait_acc = (sum > 15) ? 4'd15 : 4'(sum);
    endfunction

    function automatic void put_nibble(input logic rs, input logic [3:0] nib);
        t_nib n;
        n = '0;
        n.rs           = rs;
        n.nibble       = nib;
        n.pre_delay_ms = wait_acc;
        if (request_nibs.size() < MAX_NIBS) begin
            request_nibs.push_back(n);
        end
        wait_acc = '0;
    endfunction

    function automatic void put_byte(input logic rs, input logic [7:0] b);
        put_nibble(rs, b[7:4]);
        put_nibble(rs, b[3:0]);
    endfunction

    function automatic void clear_display();
        if (!freeze_mirror) begin
            put_byte(RS_CMD, CMD_CLEAR);
            add_wait(1);
            put_byte(RS_CMD, CMD_HOME);
            add_wait(1);
        end
    endfunction

    // Build the nibble words one request causes and queue them up
    function automatic void sequence_request(input t_req r);
        logic [2:0] ln;
        logic [7:0] row_base;
        logic [7:0] pos;
        request_nibs.delete();
        wait_acc = '0;
        ln       = r.line;
        row_base = (r.line == 3'd1) ? CMD_LINE1 : CMD_LINE2;
        pos      = row_base + 8'(r.location) - 8'd1;
        case (r.opcode)
            OP_INIT: begin
                add_wait(15); put_nibble(RS_CMD, WAKE_NIB);
                add_wait(10); put_nibble(RS_CMD, WAKE_NIB);
                add_wait(2);  put_nibble(RS_CMD, WAKE_NIB);
                add_wait(2);  put_nibble(RS_CMD, WAKE_4BIT);
                add_wait(2);  put_byte(RS_CMD, CMD_FUNC_SET);
                add_wait(2);  put_byte(RS_CMD, CMD_DISP_ON);
                add_wait(2);  put_byte(RS_CMD, CMD_SHIFT);
                add_wait(2);
                clear_display();
            end
            OP_CLEAR: begin
                clear_display();
            end
            OP_LINE: begin
                if (ln <= 3'd2) begin
                    backlight_mirror = 1'b1;
                end else begin
                    ln = ln - 3'd2;
                end
                if (!freeze_mirror) begin
                    if (ln == 3'd1) begin
                        put_byte(RS_CMD, CMD_HOME);
                        add_wait(1);
                    end else if (ln == 3'd2) begin
                        put_byte(RS_CMD, CMD_LINE2);
                        add_wait(1);
                    end
                end
            end
            OP_CHAR: begin
                if (!freeze_mirror) begin
                    if (r.value >= CHR_SPACE && r.value <= CHR_LAST) begin
                        put_byte(RS_DATA, r.value);
                    end else if (r.value == 8'h00) begin
                        put_byte(RS_DATA, CHR_SPACE);
                    end
                end
            end
            OP_CURSOR: begin
                put_byte(RS_CMD, pos); add_wait(1);
                if (r.with_arrow) begin
                    put_byte(RS_DATA, CHR_ARROW); add_wait(1);
                    put_byte(RS_DATA, CHR_DASH);  add_wait(1);
                    put_byte(RS_CMD, row_base);   add_wait(1);
                end else begin
                    put_byte(RS_CMD, pos); add_wait(1);
                end
                put_byte(RS_CMD, CMD_BLINK); add_wait(1);
            end
            OP_BYTE: begin
                put_byte(RS_CMD, pos);           add_wait(1);
                put_byte(RS_CMD, CMD_UNDERLINE); add_wait(1);
                put_byte(RS_DATA, r.value);      add_wait(1);
                put_byte(RS_CMD, pos);           add_wait(1);
            end
            OP_BCD: begin
                put_byte(RS_DATA, {CHR_DIGIT_HI, r.value[7:4]});
                put_byte(RS_DATA, {CHR_DIGIT_HI, r.value[3:0]});
                put_byte(RS_DATA, CHR_COLON);
            end
            default: ;
        endcase
        foreach (request_nibs[k]) begin
            request_nibs[k].backlight = backlight_mirror;
        end
        if (request_nibs.size() > 0) begin
            request_nibs[request_nibs.size()-1].post_delay_ms = wait_acc;
            request_nibs[request_nibs.size()-1].last          = 1'b1;
        end
        foreach (request_nibs[k]) begin
            due_nibbles.push_back(request_nibs[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_nib        exp_nib;
        logic [31:0] exp_reg;
        logic        reg_known;
        if (!i_rst_n) begin
            freeze_mirror    = 1'b0;
            pulse_mirror     = 4'd1;
            backlight_mirror = 1'b0;
            due_nibbles.delete();
            o_fail_count     = 0;
        end else begin
            // Register bus: mirror writes, check read data
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == ADDR_FREEZE) freeze_mirror = i_pwdata[0];
                    if (i_paddr == ADDR_PULSE)  pulse_mirror  = i_pwdata[3:0];
                end else begin
                    reg_known = 1'b1;
                    if (i_paddr == ADDR_FREEZE)     exp_reg = {31'd0, freeze_mirror};
                    else if (i_paddr == ADDR_PULSE) exp_reg = {28'd0, pulse_mirror};
                    else                            reg_known = 1'b0;
                    if (reg_known && i_prdata !== exp_reg) begin
                        if (o_fail_count < REPORT_MAX)
                            $display("register read at %0h: expected %h, got %h",
                                     i_paddr, exp_reg, i_prdata);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                sequence_request(i_req_data);
            end
            if (i_nib_valid && i_nib_ready) begin
                if (due_nibbles.size() == 0) begin
                    if (o_fail_count < REPORT_MAX)
                        $display("nibble word with none due: rs %b nib %h pre %0d post %0d bl %b last %b",
                                 i_nib_data.rs, i_nib_data.nibble, i_nib_data.pre_delay_ms,
                                 i_nib_data.post_delay_ms, i_nib_data.backlight,
                                 i_nib_data.last);
                    o_fail_count++;
                end else begin
                    exp_nib = due_nibbles.pop_front();
                    if (i_nib_data.rs            !== exp_nib.rs            ||
                        i_nib_data.nibble        !== exp_nib.nibble        ||
                        i_nib_data.pre_delay_ms  !== exp_nib.pre_delay_ms  ||
                        i_nib_data.post_delay_ms !== exp_nib.post_delay_ms ||
                        i_nib_data.backlight     !== exp_nib.backlight     ||
                        i_nib_data.last          !== exp_nib.last) begin
                        if (o_fail_count < REPORT_MAX) begin
                            $display("nibble word mismatch at %0t", $realtime);
                            $display("  expected rs %b nib %h pre %0d post %0d bl %b last %b",
                                     exp_nib.rs, exp_nib.nibble, exp_nib.pre_delay_ms,
                                     exp_nib.post_delay_ms, exp_nib.backlight, exp_nib.last);
                            $display("  actual   rs %b nib %h pre %0d post %0d bl %b last %b",
                                     i_nib_data.rs, i_nib_data.nibble,
                                     i_nib_data.pre_delay_ms, i_nib_data.post_delay_ms,
                                     i_nib_data.backlight, i_nib_data.last);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_nibbles.size();
    end

endmodule

@@ tb/char_lcd_nibble_sequencer_core_tb.sv @@
// Top of the testbench for the character-LCD nibble sequencer: clock, reset,
// register writes, request stimulus, output back-pressure and the verdict.
// Depends on clns_pkg, the channel interfaces, the block and its checker.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_core_tb;
    import clns_pkg::*;

    localparam logic [2:0] OP_UNUSED       = 3'd7;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 32;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                nibbles_due;

    // Idling controls for the request and nibble sides
    bit sender_idle;
    bit receiver_idle;
    bit hold_off_pending;

    clns_req_if req_bus ();
    clns_nib_if nib_bus ();

    char_lcd_nibble_sequencer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_nib   (nib_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    char_lcd_nibble_sequencer_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_bus.valid),
        .i_req_ready  (req_bus.ready),
        .i_req_data   (req_bus.data),
        .i_nib_valid  (nib_bus.valid),
        .i_nib_ready  (nib_bus.ready),
        .i_nib_data   (nib_bus.data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (nibbles_due)
    );

    always #5 clk = ~clk;

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Nibble side: random stall bursts, plus one long hold-off on request
    initial begin
        nib_bus.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (hold_off_pending) begin
                // hold off long enough for the queue to fill and stall requests
                hold_off_pending = 1'b0;
                nib_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                nib_bus.ready <= 1'b1;
            end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
                nib_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                nib_bus.ready <= 1'b1;
            end else begin
                nib_bus.ready <= 1'b1;
            end
        end
    end

    function automatic t_req make_req(input logic [2:0] op, input logic [7:0] val,
                                      input logic [2:0] ln, input logic [5:0] loc,
                                      input logic arrow);
        t_req r;
        r.opcode     = op;
        r.value      = val;
        r.line       = ln;
        r.location   = loc;
        r.with_arrow = arrow;
        return r;
    endfunction

    // Mostly well-formed requests, with a share of odd lines, columns and codes
    function automatic t_req random_req();
        t_req        r;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        r.value      = 8'($urandom);
        r.line       = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 4))
                                                     : 3'($urandom_range(0, 7));
        r.location   = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, 40))
                                                     : 6'($urandom_range(0, 63));
        r.with_arrow = 1'($urandom);
        if (pick < 4)       r.opcode = OP_INIT;
        else if (pick < 14) r.opcode = OP_CLEAR;
        else if (pick < 29) r.opcode = OP_LINE;
        else if (pick < 54) r.opcode = OP_CHAR;
        else if (pick < 69) r.opcode = OP_CURSOR;
        else if (pick < 84) r.opcode = OP_BYTE;
        else if (pick < 97) r.opcode = OP_BCD;
        else                r.opcode = OP_UNUSED;
        if (r.opcode == OP_CHAR) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)       r.value = 8'($urandom_range(32'h20, 32'h7E));
            else if (pick == 7) r.value = 8'h00;
        end
        return r;
    endfunction

    // Offer one request word and hold until it is taken
    task automatic push_request(input t_req r);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
    endtask

    task automatic push_random(input int count);
        repeat (count) push_request(random_req());
    endtask

    // Write a register, leave the bus idle, then read it back
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every due nibble word, then let the block go quiet
    task automatic drain();
        req_bus.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (nibbles_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        rst_n         <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        hold_off_pending = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(ADDR_FREEZE, 32'd0);
        write_register(ADDR_PULSE, 32'd1);

        // Directed: every operation, line and character edges, wrapped columns
        push_request(make_req(OP_INIT,   8'h00, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CLEAR,  8'hFF, 3'd7, 6'd63, 1'b1));
        push_request(make_req(OP_LINE,   8'h00, 3'd3, 6'd1,  1'b0));
        push_request(make_req(OP_LINE,   8'h00, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_LINE,   8'h00, 3'd4, 6'd1,  1'b0));
        push_request(make_req(OP_LINE,   8'h00, 3'd2, 6'd1,  1'b0));
        push_request(make_req(OP_LINE,   8'h00, 3'd0, 6'd1,  1'b0));
        push_request(make_req(OP_LINE,   8'h00, 3'd7, 6'd1,  1'b0));
        push_request(make_req(OP_CHAR,   8'h20, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CHAR,   8'h7E, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CHAR,   8'h00, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CHAR,   8'h1F, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CHAR,   8'hFF, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_CURSOR, 8'h00, 3'd1, 6'd1,  1'b1));
        push_request(make_req(OP_CURSOR, 8'h00, 3'd2, 6'd40, 1'b0));
        push_request(make_req(OP_CURSOR, 8'h00, 3'd3, 6'd0,  1'b1));
        push_request(make_req(OP_CURSOR, 8'h00, 3'd0, 6'd63, 1'b0));
        push_request(make_req(OP_BYTE,   8'hFF, 3'd1, 6'd40, 1'b0));
        push_request(make_req(OP_BYTE,   8'h00, 3'd2, 6'd1,  1'b1));
        push_request(make_req(OP_BCD,    8'h00, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_BCD,    8'h99, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_BCD,    8'hFF, 3'd1, 6'd1,  1'b0));
        push_request(make_req(OP_UNUSED, 8'hFF, 3'd7, 6'd63, 1'b1));
        push_random(40);
        drain();

        // Frozen display: clear, line start and characters go silent
        write_register(ADDR_FREEZE, 32'd1);
        write_register(ADDR_PULSE, 32'd7);
        push_request(make_req(OP_INIT,  8'h00, 3'd1, 6'd1, 1'b0));
        push_request(make_req(OP_CLEAR, 8'h00, 3'd1, 6'd1, 1'b0));
        push_request(make_req(OP_LINE,  8'h00, 3'd4, 6'd1, 1'b0));
        push_request(make_req(OP_CHAR,  8'h41, 3'd1, 6'd1, 1'b0));
        push_random(25);
        drain();

        // Long hold-off on the nibble side while requests keep coming
        write_register(ADDR_FREEZE, 32'd0);
        write_register(ADDR_PULSE, 32'd15);
        sender_idle      = 1'b0;
        hold_off_pending = 1'b1;
        push_random(40);
        drain();

        // Final stretch at full rate, no idling on either side
        write_register(ADDR_PULSE, 32'd4);
        receiver_idle = 1'b0;
        push_random(50);
        drain();

        if (fail_count == 0 && nibbles_due == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/clns_pkg.sv
rtl/clns_if.sv
rtl/clns_front.sv
rtl/clns_queue.sv
rtl/clns_back.sv
rtl/char_lcd_nibble_sequencer_core.sv
rtl/clns_checker.sv
tb/char_lcd_nibble_sequencer_checker.sv
tb/char_lcd_nibble_sequencer_core_tb.sv
